// File: rtl/rgbhsv_pkg.sv
// Shared types, constants and stage record for the RGB to HSV converter.
`default_nettype none
package rgbhsv_pkg;

  // Hue arithmetic in 1/64 degree units.
  localparam int unsigned HUE_SCALE     = 3840;   // 64 * 60
  localparam int unsigned HUE_SECTOR    = 7680;   // 64 * 120
  localparam int unsigned HUE_FULL_TURN = 23040;  // 64 * 360

  // Divider chain geometry: one quotient bit per cell.
  localparam int unsigned QUO_W     = 12;
  localparam int unsigned NUM_CELLS = QUO_W;
  localparam int unsigned DIV_W     = 8 + QUO_W - 1;
  localparam int unsigned REM_W     = DIV_W + 1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [14:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  value;
  } hsv_t;

  typedef enum logic [1:0] {
    SECTOR_RED   = 2'd0,
    SECTOR_GREEN = 2'd1,
    SECTOR_BLUE  = 2'd2
  } sector_t;

  // Everything one pixel carries down the divider chain.
  typedef struct packed {
    logic [REM_W-1:0] hue_rem;
    logic [DIV_W-1:0] hue_div;
    logic [QUO_W-1:0] hue_quo;
    logic [REM_W-1:0] sat_rem;
    logic [DIV_W-1:0] sat_div;
    logic [QUO_W-1:0] sat_quo;
    logic             neg;
    logic             grey;
    sector_t          sector;
    logic [7:0]       value;
  } stage_t;

endpackage
`default_nettype wire

// File: rtl/rgbhsv_prep.sv
// Front stage: max, min, sector selection and the two dividends.
`default_nettype none
module rgbhsv_prep (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            valid,
  input  wire rgbhsv_pkg::pixel_t pixel,
  input  wire logic            hold_in,
  output logic                 hold_out,
  output logic                 out_valid,
  output rgbhsv_pkg::stage_t   out_data
);

  logic [7:0]         mx;
  logic [7:0]         mn;
  logic [7:0]         delta;
  logic [8:0]         num;
  logic [7:0]         mag;
  rgbhsv_pkg::sector_t sector;
  rgbhsv_pkg::stage_t  data_next;

  always_comb begin
    mx = pixel.red;
    mn = pixel.red;
    if (pixel.green > mx) mx = pixel.green;
    if (pixel.blue > mx) mx = pixel.blue;
    if (pixel.green < mn) mn = pixel.green;
    if (pixel.blue < mn) mn = pixel.blue;
    delta = mx - mn;

    // Red wins ties over green, and green over blue.
    if (mx == pixel.red) begin
      sector = rgbhsv_pkg::SECTOR_RED;
      num    = {1'b0, pixel.green} - {1'b0, pixel.blue};
    end else if (mx == pixel.green) begin
      sector = rgbhsv_pkg::SECTOR_GREEN;
      num    = {1'b0, pixel.blue} - {1'b0, pixel.red};
    end else begin
      sector = rgbhsv_pkg::SECTOR_BLUE;
      num    = {1'b0, pixel.red} - {1'b0, pixel.green};
    end
    mag = num[8] ? 8'(-num) : num[7:0];

    data_next.hue_rem = {mag, 12'b0} - {4'b0, mag, 8'b0};
    data_next.hue_div = {delta, 11'b0};
    data_next.hue_quo = '0;
    data_next.sat_rem = {4'b0, delta, 8'b0} - {12'b0, delta};
    data_next.sat_div = {mx, 11'b0};
    data_next.sat_quo = '0;
    data_next.neg     = num[8];
    data_next.grey    = (delta == 8'd0);
    data_next.sector  = sector;
    data_next.value   = mx;
  end

  assign hold_out = out_valid & hold_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!hold_out) begin
      out_valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold_out && valid) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/rgbhsv_cell.sv
// One divider cell: a restoring step for the hue and saturation quotients.
`default_nettype none
module rgbhsv_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               valid,
  input  wire rgbhsv_pkg::stage_t in_data,
  input  wire logic               hold_in,
  output logic                    hold_out,
  output logic                    out_valid,
  output rgbhsv_pkg::stage_t      out_data
);

  logic               hue_ge;
  logic               sat_ge;
  rgbhsv_pkg::stage_t data_next;

  // The divisor arrives pre-shifted and moves one place right per cell.
  always_comb begin
    data_next = in_data;
    hue_ge = in_data.hue_rem >= {1'b0, in_data.hue_div};
    sat_ge = in_data.sat_rem >= {1'b0, in_data.sat_div};
    if (hue_ge) data_next.hue_rem = in_data.hue_rem - {1'b0, in_data.hue_div};
    if (sat_ge) data_next.sat_rem = in_data.sat_rem - {1'b0, in_data.sat_div};
    data_next.hue_quo = {in_data.hue_quo[rgbhsv_pkg::QUO_W-2:0], hue_ge};
    data_next.sat_quo = {in_data.sat_quo[rgbhsv_pkg::QUO_W-2:0], sat_ge};
    data_next.hue_div = in_data.hue_div >> 1;
    data_next.sat_div = in_data.sat_div >> 1;
  end

  assign hold_out = out_valid & hold_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!hold_out) begin
      out_valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold_out && valid) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/rgbhsv_finish.sv
// Output stage: floor correction, sector offset, wrap and result register.
`default_nettype none
module rgbhsv_finish (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               valid,
  input  wire rgbhsv_pkg::stage_t in_data,
  input  wire logic               stall,
  output logic                    hold_out,
  output logic                    out_valid,
  output rgbhsv_pkg::hsv_t        out_data
);

  logic [12:0]      quo_adj;
  logic [15:0]      offset;
  logic [15:0]      hue_sum;
  logic [14:0]      hue_wrap;
  rgbhsv_pkg::hsv_t data_next;

  always_comb begin
    // A negative numerator rounds toward minus infinity: bump by one on remainder.
    quo_adj = {1'b0, in_data.hue_quo};
    if (in_data.neg && (in_data.hue_rem != '0)) quo_adj = quo_adj + 13'd1;

    case (in_data.sector)
      rgbhsv_pkg::SECTOR_RED:   offset = 16'd0;
      rgbhsv_pkg::SECTOR_GREEN: offset = 16'(rgbhsv_pkg::HUE_SECTOR);
      rgbhsv_pkg::SECTOR_BLUE:  offset = 16'(2 * rgbhsv_pkg::HUE_SECTOR);
      default:                  offset = 16'd0;
    endcase

    if (in_data.neg) hue_sum = offset - {3'b0, quo_adj};
    else             hue_sum = offset + {3'b0, quo_adj};

    if (hue_sum[15]) hue_wrap = 15'(hue_sum + 16'(rgbhsv_pkg::HUE_FULL_TURN));
    else             hue_wrap = hue_sum[14:0];

    data_next.value = in_data.value;
    if (in_data.grey) begin
      data_next.hue        = '0;
      data_next.saturation = '0;
    end else begin
      data_next.hue        = hue_wrap;
      data_next.saturation = in_data.sat_quo[7:0];
    end
  end

  assign hold_out = out_valid & stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!hold_out) begin
      out_valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold_out && valid) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/rgb_to_hsv.sv
// Top level of the RGB to HSV converter.
//
// Converts one 8-bit RGB pixel per clock, while pixel_stall is low, into hue
// (1/64 degree units), saturation and value, each rounded down. A pixel
// passes through one front stage, a chain of twelve divider cells (one
// quotient bit each, hue and saturation side by side), and one output stage.
// Every stage holds its own valid bit, so a stalled result only backs up the
// stages behind it, and empty stages keep filling.
`default_nettype none
module rgb_to_hsv (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             pixel_valid,
  output logic                  pixel_stall,
  input  wire rgbhsv_pkg::pixel_t pixel,
  output logic                  hsv_valid,
  input  wire logic             hsv_stall,
  output rgbhsv_pkg::hsv_t      hsv
);

  localparam int unsigned N = rgbhsv_pkg::NUM_CELLS;

  rgbhsv_pkg::stage_t stage_data  [N+1];
  logic               stage_valid [N+1];
  // The last entry is the hold from the output stage.
  logic               stage_hold  [N+2];

  rgbhsv_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .valid     (pixel_valid),
    .pixel     (pixel),
    .hold_in   (stage_hold[1]),
    .hold_out  (stage_hold[0]),
    .out_valid (stage_valid[0]),
    .out_data  (stage_data[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    rgbhsv_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid     (stage_valid[i]),
      .in_data   (stage_data[i]),
      .hold_in   (stage_hold[i+2]),
      .hold_out  (stage_hold[i+1]),
      .out_valid (stage_valid[i+1]),
      .out_data  (stage_data[i+1])
    );
  end

  rgbhsv_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .valid     (stage_valid[N]),
    .in_data   (stage_data[N]),
    .stall     (hsv_stall),
    .hold_out  (stage_hold[N+1]),
    .out_valid (hsv_valid),
    .out_data  (hsv)
  );

  assign pixel_stall = stage_hold[0];

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> (hsv.hue < 15'(rgbhsv_pkg::HUE_FULL_TURN)))
    else $error("hue out of range");

  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && hsv.saturation == 8'd0) |-> (hsv.hue == 15'd0))
    else $error("zero saturation with nonzero hue");

  a_black_sat: assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && hsv.value == 8'd0) |-> (hsv.saturation == 8'd0))
    else $error("black pixel with nonzero saturation");

endmodule
`default_nettype wire
